@@ sv/assert_macros.svh @@
// Assertion macros shared by the matcher RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of aclk while out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that a condition never holds on a clock edge while out of reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

@@ sv/sssm_pkg.sv @@
// Package for the substring search matcher: beat types, register indexes, constants.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package sssm_pkg;

    localparam int MAX_KEY_LEN_DEF = 8;
    localparam int KEY_W           = 64;
    localparam int LEN_W           = 4;
    localparam int POS_W           = 32;
    localparam int CFG_IDX_W       = 4;
    localparam int CFG_DATA_W      = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN   = CFG_IDX_W'(1);

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    typedef struct packed {
        logic [7:0] source_byte;
        logic       last;
    } in_beat_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] end_pos;
        logic             done_res;
    } out_beat_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ sv/substring_search_matcher_top.sv @@
// Substring search matcher top level: config registers, input register, matcher, result queue.
// Depends on sssm_pkg, sssm_match, sssm_out_queue and assert_macros.svh.
//
//   channel | direction | signals                               | payload
//   s_      | in        | s_valid, s_ready, s_data              | in_beat_t
//   m_      | out       | m_valid, m_ready, m_data              | out_beat_t
//   cfg_    | in        | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// One source byte per clock while s_ready is high; a beat's result passes the input register,
// then the window compare into the result queue, before it leaves.
// Reset: synchronous aresetn clears control, position and restart count; no clearing pass.
// Stalls: the two-entry result queue absorbs one waiting result; s_ready drops only
// when both entries are held and the input register is occupied.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module substring_search_matcher_top import sssm_pkg::*; #(
    parameter int MAX_KEY_LEN = MAX_KEY_LEN_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_beat_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_beat_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [KEY_W-1:0] key_bytes_reg, key_bytes_next;
    logic [LEN_W-1:0] key_len_reg, key_len_next;
    logic             in_valid_reg, in_valid_next;
    in_beat_t         in_data_reg;

    logic      s_take;
    logic      advance;
    logic      res_valid;
    out_beat_t res_beat;
    logic      out_push;
    q_status_t q_stat;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && !q_stat.full;
    assign s_ready   = !in_valid_reg || advance;
    assign s_take    = s_valid && s_ready;
    assign out_push  = advance && res_valid;

    always_comb begin
        key_bytes_next = key_bytes_reg;
        key_len_next   = key_len_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_KEY_BYTES: key_bytes_next = cfg_data[KEY_W-1:0];
                CFG_KEY_LEN:   key_len_next   = cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_bytes_reg <= '0;
            key_len_reg   <= LEN_W'(1);
            in_valid_reg  <= 1'b0;
        end else begin
            key_bytes_reg <= key_bytes_next;
            key_len_reg   <= key_len_next;
            in_valid_reg  <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_data_reg <= s_data;
        end
    end

    sssm_match #(
        .MAX_KEY_LEN(MAX_KEY_LEN)
    ) u_match (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_beat   (in_data_reg),
        .key_bytes (key_bytes_reg),
        .key_len   (key_len_reg),
        .res_valid (res_valid),
        .res_beat  (res_beat)
    );

    sssm_out_queue u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (out_push),
        .push_beat (res_beat),
        .status    (q_stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    `ASSERT_NEVER(a_no_overflow, out_push && q_stat.full, "result queue overflow")
    `ASSERT_CLK(a_stall_held, !s_ready |-> in_valid_reg, "input stalled with empty register")
    `ASSERT_CLK(a_found_pos, m_valid && m_data.found |-> m_data.end_pos != '0, "match at zero")
    `ASSERT_CLK(a_empty_res, m_valid && !m_data.found |-> m_data.done_res, "empty result beat")

endmodule

@@ sv/sssm_match.sv @@
// Window compare and stream state (recent bytes, position, restart count).
// Depends on sssm_pkg.
`timescale 1ns / 1ps

module sssm_match import sssm_pkg::*; #(
    parameter int MAX_KEY_LEN = MAX_KEY_LEN_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  in_beat_t         in_beat,
    input  logic [KEY_W-1:0] key_bytes,
    input  logic [LEN_W-1:0] key_len,
    output logic             res_valid,
    output out_beat_t        res_beat
);

    localparam int HIST_D = (MAX_KEY_LEN > 1) ? MAX_KEY_LEN - 1 : 1;
    localparam logic [LEN_W-1:0] MAX_L = LEN_W'(MAX_KEY_LEN);

    logic [7:0]       hist_reg [HIST_D];
    logic [7:0]       hist_next[HIST_D];
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0] since_reg, since_next;

    logic [7:0]             win[MAX_KEY_LEN];
    logic [LEN_W-1:0]       eff_len;
    logic [LEN_W-1:0]       since_inc;
    logic [POS_W-1:0]       pos_inc;
    logic [MAX_KEY_LEN-1:0] len_hit;
    logic                   sel_hit;
    logic                   match;

    assign win[0] = in_beat.source_byte;
    for (genvar j = 1; j < MAX_KEY_LEN; j++) begin : g_win
        assign win[j] = hist_reg[j-1];
    end

    always_comb begin
        if (key_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (key_len > MAX_L) begin
            eff_len = MAX_L;
        end else begin
            eff_len = key_len;
        end
    end

    // one compare per candidate key length; key byte i against window lane len-1-i
    always_comb begin
        for (int l = 0; l < MAX_KEY_LEN; l++) begin
            len_hit[l] = 1'b1;
            for (int i = 0; i <= l; i++) begin
                if (key_bytes[8*i +: 8] != win[l-i]) begin
                    len_hit[l] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        sel_hit = 1'b0;
        for (int l = 0; l < MAX_KEY_LEN; l++) begin
            if (eff_len == LEN_W'(l + 1)) begin
                sel_hit = len_hit[l];
            end
        end
    end

    assign since_inc = (since_reg < MAX_L) ? since_reg + LEN_W'(1) : since_reg;
    assign pos_inc   = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);
    assign match     = (since_inc >= eff_len) && sel_hit;

    assign res_valid         = match || in_beat.last;
    assign res_beat.found    = match;
    assign res_beat.end_pos  = match ? pos_inc : '0;
    assign res_beat.done_res = in_beat.last;

    always_comb begin
        hist_next[0] = in_beat.source_byte;
        for (int j = 1; j < HIST_D; j++) begin
            hist_next[j] = hist_reg[j-1];
        end
        if (in_beat.last) begin
            pos_next   = '0;
            since_next = '0;
        end else begin
            pos_next   = pos_inc;
            since_next = match ? '0 : since_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            since_reg <= '0;
        end else if (advance) begin
            pos_reg   <= pos_next;
            since_reg <= since_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            hist_reg <= hist_next;
        end
    end

endmodule

@@ sv/sssm_out_queue.sv @@
// Two-entry result queue; lets the matcher keep taking beats while a result waits.
// Depends on sssm_pkg.
`timescale 1ns / 1ps

module sssm_out_queue import sssm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  out_beat_t push_beat,
    output q_status_t status,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    out_beat_t  slot_reg[2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign m_valid      = (count_reg != 2'd0);
    assign m_data       = slot_reg[rd_ptr_reg];
    assign pop          = m_valid && m_ready;
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_beat;
        end
    end

endmodule
